### hdl/encspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encspd_pkg
// Widths, types and constants for the encoder speed and turn tracker.
// ----------------------------------------------------------------------------
package encspd_pkg;

    localparam int ANGLE_W    = 12;
    localparam int INTERVAL_W = 24;
    localparam int SPEED_W    = 26;
    localparam int STEP_W     = 13;
    localparam int TURNS_W    = 32;
    localparam int MAG_W      = 12;
    localparam int PROD_W     = 25;
    localparam int SCALE_W    = 14;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 72;
    localparam int CNT_W      = 5;

    localparam logic [SCALE_W-1:0] RPM_SCALE = 14'd14648;
    localparam logic [STEP_W-1:0]  HALF_TURN = 13'sd2048;
    localparam logic [STEP_W-1:0]  FULL_TURN = 13'd4096;

    typedef logic [ANGLE_W-1:0]           angle_t;
    typedef logic [INTERVAL_W-1:0]        interval_t;
    typedef logic signed [SPEED_W-1:0]    speed_t;
    typedef logic signed [STEP_W-1:0]     step_t;
    typedef logic signed [TURNS_W-1:0]    turns_t;
    typedef logic [PROD_W-1:0]            prod_t;

endpackage
`default_nettype wire

### hdl/encoder_speed_and_turn_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_and_turn_tracker
// Wrap-aware angle step, signed turn count and RPM estimate per sample.
// ----------------------------------------------------------------------------
// One input transaction gives one output transaction. The step and turn count
// are settled in the accept cycle; the speed |step|*14648/interval is formed
// by a bit-serial shift-add multiplier (one step bit per cycle) followed by a
// restoring divider (one quotient bit per cycle). The output register is
// loaded from the done state once the divider finishes, and a new item is
// accepted the cycle after that load even while the result still waits on the
// output side, so the block does not take a new item before the last one is
// loaded. A result left waiting on the output side holds the next one in its
// load cycle. A zero interval gives speed 0.
module encoder_speed_and_turn_tracker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] angle, [35:12] interval_us, [39:36] zero
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [25:0] speed, [38:26] angle_step, [70:39] turns, [71] zero
    output logic [71:0]      m_axis_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [encspd_pkg::CNT_W-1:0] MUL_LAST =
        encspd_pkg::CNT_W'(encspd_pkg::MAG_W - 1);
    localparam logic [encspd_pkg::CNT_W-1:0] DIV_LAST =
        encspd_pkg::CNT_W'(encspd_pkg::PROD_W - 1);

    logic [1:0] state_reg, state_next;
    logic [encspd_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    encspd_pkg::angle_t    prev_reg, prev_next;
    encspd_pkg::turns_t    turns_reg, turns_next;
    encspd_pkg::step_t     step_reg, step_next;
    encspd_pkg::interval_t div_reg, div_next;
    logic [encspd_pkg::MAG_W-1:0] mag_reg, mag_next;
    encspd_pkg::prod_t     kshift_reg, kshift_next;
    encspd_pkg::prod_t     acc_reg, acc_next;
    logic [encspd_pkg::INTERVAL_W-1:0] rem_reg, rem_next;

    logic out_valid_reg, out_valid_next;
    encspd_pkg::speed_t out_speed_reg, out_speed_next;
    encspd_pkg::step_t  out_step_reg, out_step_next;
    encspd_pkg::turns_t out_turns_reg, out_turns_next;

    logic                  in_fire;
    logic                  load;
    encspd_pkg::angle_t    in_angle;
    encspd_pkg::interval_t in_interval;
    encspd_pkg::step_t     diff;
    encspd_pkg::step_t     step_abs;
    logic [encspd_pkg::PROD_W-1:0] rem_sh;
    logic [encspd_pkg::PROD_W:0]   rem_sub;
    logic [encspd_pkg::SPEED_W-1:0] q_ext;

    assign in_angle    = s_axis_tdata[11:0];
    assign in_interval = s_axis_tdata[35:12];
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign diff = encspd_pkg::step_t'({1'b0, in_angle}) -
                  encspd_pkg::step_t'({1'b0, prev_reg});

    assign rem_sh  = {rem_reg, acc_reg[encspd_pkg::PROD_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, div_reg};
    assign q_ext   = {1'b0, acc_reg};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prev_next   = prev_reg;
        turns_next  = turns_reg;
        step_next   = step_reg;
        div_next    = div_reg;
        mag_next    = mag_reg;
        kshift_next = kshift_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        step_abs    = '0;
        out_valid_next = out_valid_reg;
        out_speed_next = out_speed_reg;
        out_step_next  = out_step_reg;
        out_turns_next = out_turns_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (diff > $signed(encspd_pkg::HALF_TURN))
                    begin
                        step_next  = diff - encspd_pkg::FULL_TURN;
                        turns_next = turns_reg - 32'sd1;
                    end
                    else if (diff < -$signed(encspd_pkg::HALF_TURN))
                    begin
                        step_next  = diff + encspd_pkg::FULL_TURN;
                        turns_next = turns_reg + 32'sd1;
                    end
                    else
                    begin
                        step_next = diff;
                    end
                    step_abs    = step_next[encspd_pkg::STEP_W-1] ? -step_next : step_next;
                    mag_next    = step_abs[encspd_pkg::MAG_W-1:0];
                    prev_next   = in_angle;
                    div_next    = in_interval;
                    kshift_next = encspd_pkg::PROD_W'(encspd_pkg::RPM_SCALE);
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mag_reg[0])
                begin
                    acc_next = acc_reg + kshift_reg;
                end
                mag_next    = mag_reg >> 1;
                kshift_next = kshift_reg << 1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (!rem_sub[encspd_pkg::PROD_W])
                begin
                    rem_next = rem_sub[encspd_pkg::INTERVAL_W-1:0];
                    acc_next = {acc_reg[encspd_pkg::PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[encspd_pkg::INTERVAL_W-1:0];
                    acc_next = {acc_reg[encspd_pkg::PROD_W-2:0], 1'b0};
                end
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_step_next  = step_reg;
                    out_turns_next = turns_reg;
                    if (div_reg == '0)
                    begin
                        out_speed_next = '0;
                    end
                    else if (step_reg[encspd_pkg::STEP_W-1])
                    begin
                        out_speed_next = -$signed(q_ext);
                    end
                    else
                    begin
                        out_speed_next = $signed(q_ext);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            turns_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            turns_reg     <= turns_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        div_reg       <= div_next;
        mag_reg       <= mag_next;
        kshift_reg    <= kshift_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        out_speed_reg <= out_speed_next;
        out_step_reg  <= out_step_next;
        out_turns_reg <= out_turns_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_turns_reg, out_step_reg, out_speed_reg};

    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_MUL)
        else $error("accepted transaction did not start multiply");

    a_turns_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(turns_reg))
        else $error("turn count changed without a transaction");

    a_zero_interval_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (load && div_reg == '0) |=> out_speed_reg == '0)
        else $error("zero interval gave nonzero speed");

    a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= DIV_LAST)
        else $error("divider count out of range");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result load did not raise tvalid");

endmodule
`default_nettype wire
